// ----- sv/asfur_pkg.sv -----
// shared types and constants for the audio sample fifo with underrun replay
`default_nettype none

package asfur_pkg;

  localparam int FUNC_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 13;
  localparam int CH_W     = 2;
  localparam int BLK_W    = 12;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CH_W-1:0]  CH_RESET  = 2'd1;
  localparam logic [BLK_W-1:0] BLK_RESET = 12'd512;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_SILENCE = 3'd1,
    FUNC_READ    = 3'd2,
    FUNC_SKIP    = 3'd3,
    FUNC_PAUSE   = 3'd4
  } func_t;

  typedef enum logic [0:0] {
    REG_CHANNELS = 1'b0,
    REG_BLOCK    = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_FILL,
    ST_ZERO,
    ST_RD_NEXT,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_REWIND
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic latch;
    logic exec;
    logic fill_step;
    logic rd_issue;
    logic rd_load;
    logic rewind;
    logic zero_load;
    logic stat_load;
  } cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic              slot_free;
    logic [FUNC_W-1:0] func;
    logic              paused;
    logic              burst_zero;
    logic              avail_zero;
    logic              fill_left_zero;
    logic              burst_last;
    logic              replay;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/asfur_regs.sv -----
// configuration registers behind the apb-style port
`default_nettype none

module asfur_regs
  import asfur_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CH_W-1:0]   channel_count,
  output logic      [BLK_W-1:0]  block_frames
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CH_RESET;
      block_frames  <= BLK_RESET;
    end else if (wr) begin
      case (idx)
        REG_CHANNELS: channel_count <= pwdata[CH_W-1:0];
        REG_BLOCK:    block_frames  <= pwdata[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNELS: prdata = DATA_W'(channel_count);
      REG_BLOCK:    prdata = DATA_W'(block_frames);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/asfur_dp.sv -----
// datapath: sample store, pointers, fill count, item registers and output register
`default_nettype none

module asfur_dp
  import asfur_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  input  wire logic        [FUNC_W-1:0]   func,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic        [COUNT_W-1:0]  count,
  input  wire logic                       pause_flag,
  input  wire logic        [CH_W-1:0]     channel_count,
  input  wire logic        [BLK_W-1:0]    block_frames,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic signed      [SAMPLE_W-1:0] sample_out,
  output logic                            last,
  output logic                            underrun,
  output logic                            dropped,
  output logic             [COUNT_W-1:0]  accepted,
  output logic             [COUNT_W-1:0]  fill_level,
  output logic                            playing
);

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int BURST_W   = $clog2(MAX_BURST + 1);
  localparam int AW        = (CNT_W > 15 ? CNT_W : 15) + 1;
  localparam int REW_STEPS = MAX_BURST / DEPTH;
  localparam logic [AW-1:0]    DEPTH_A = AW'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata;

  logic [PTR_W-1:0]    rptr;
  logic [PTR_W-1:0]    wptr;
  logic [CNT_W-1:0]    fill;
  logic                awaiting;
  logic                paused;
  logic [PTR_W-1:0]    clr_addr;

  logic [FUNC_W-1:0]   func_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [COUNT_W-1:0]  count_q;
  logic                pflag_q;

  logic                drop_q;
  logic [CNT_W-1:0]    acc_q;
  logic [CNT_W-1:0]    fill_left;
  logic [BURST_W-1:0]  burst_left;
  logic [BURST_W-1:0]  avail_left;
  logic                replay;

  logic                slot_free;
  logic                out_load;

  logic [AW-1:0]       fill_a;
  logic [AW-1:0]       thr;
  logic                full;
  logic [AW-1:0]       fill_inc;
  logic [AW-1:0]       sil_n;
  logic [AW-1:0]       cap;
  logic                sil_over;
  logic [AW-1:0]       sil_sat;
  logic [AW-1:0]       fill_sil;
  logic [AW-1:0]       burst_n;
  logic [AW-1:0]       avail_n;
  logic [AW-1:0]       skip_n;
  logic [AW-1:0]       skip_sum;
  logic [AW-1:0]       rew_off;
  logic [AW-1:0]       rew_ptr;
  logic [PTR_W-1:0]    rptr_inc;
  logic [PTR_W-1:0]    wptr_inc;

  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  assign fill_a   = AW'(fill);
  assign thr      = AW'(block_frames) * AW'(channel_count);
  assign full     = fill_a >= DEPTH_A;
  assign fill_inc = fill_a + AW'(1);
  assign sil_n    = AW'(count_q) * AW'(channel_count);
  assign cap      = DEPTH_A - fill_a;
  assign sil_over = sil_n > cap;
  assign sil_sat  = sil_over ? cap : sil_n;
  assign fill_sil = fill_a + sil_sat;
  assign burst_n  = (AW'(count_q) > AW'(MAX_BURST)) ? AW'(MAX_BURST) : AW'(count_q);
  assign avail_n  = (burst_n < fill_a) ? burst_n : fill_a;
  assign skip_n   = (AW'(count_q) < fill_a) ? AW'(count_q) : fill_a;
  assign skip_sum = AW'(rptr) + skip_n;
  assign rptr_inc = (rptr == PTR_MAX) ? '0 : rptr + PTR_W'(1);
  assign wptr_inc = (wptr == PTR_MAX) ? '0 : wptr + PTR_W'(1);

  // replay start: rewind by the shortfall modulo the depth
  always_comb begin
    rew_off = AW'(burst_left);
    for (int i = 0; i < REW_STEPS; i++) begin
      if (rew_off >= DEPTH_A) begin
        rew_off = rew_off - DEPTH_A;
      end
    end
    if (AW'(rptr) >= rew_off) begin
      rew_ptr = AW'(rptr) - rew_off;
    end else begin
      rew_ptr = AW'(rptr) + DEPTH_A - rew_off;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = '0;
    if (cmd.clear_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
    end else if (cmd.exec && func_q == FUNC_PUSH && !paused && !full) begin
      mem_we    = 1'b1;
      mem_wdata = sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[rptr];
    end
  end

  // item fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q   <= func;
      sample_q <= sample_in;
      count_q  <= count;
      pflag_q  <= pause_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr     <= '0;
      wptr     <= '0;
      fill     <= '0;
      awaiting <= 1'b1;
      paused   <= 1'b0;
      clr_addr <= '0;
      replay   <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + PTR_W'(1);
      end
      if (cmd.exec) begin
        burst_left <= BURST_W'(burst_n);
        replay     <= 1'b0;
        case (func_q)
          FUNC_PUSH: begin
            drop_q     <= !paused && full;
            acc_q      <= (!paused && !full) ? CNT_W'(1) : '0;
            fill_left  <= '0;
            avail_left <= '0;
            if (!paused && !full) begin
              wptr <= wptr_inc;
              fill <= CNT_W'(fill_inc);
              if (fill_inc >= thr) begin
                awaiting <= 1'b0;
              end
            end
          end
          FUNC_SILENCE: begin
            drop_q     <= !paused && sil_over;
            acc_q      <= paused ? '0 : CNT_W'(sil_sat);
            fill_left  <= paused ? '0 : CNT_W'(sil_sat);
            avail_left <= '0;
            if (!paused) begin
              fill <= CNT_W'(fill_sil);
              if (fill_sil >= thr) begin
                awaiting <= 1'b0;
              end
            end
          end
          FUNC_READ: begin
            drop_q     <= 1'b0;
            acc_q      <= '0;
            fill_left  <= '0;
            avail_left <= paused ? '0 : BURST_W'(avail_n);
            if (!paused) begin
              fill <= CNT_W'(fill_a - avail_n);
            end
          end
          FUNC_SKIP: begin
            drop_q     <= 1'b0;
            acc_q      <= CNT_W'(skip_n);
            fill_left  <= '0;
            avail_left <= '0;
            fill       <= CNT_W'(fill_a - skip_n);
            rptr       <= PTR_W'((skip_sum >= DEPTH_A) ? skip_sum - DEPTH_A : skip_sum);
          end
          FUNC_PAUSE: begin
            drop_q     <= 1'b0;
            acc_q      <= '0;
            fill_left  <= '0;
            avail_left <= '0;
            if (pflag_q != paused) begin
              fill     <= '0;
              rptr     <= '0;
              wptr     <= '0;
              awaiting <= 1'b1;
              paused   <= pflag_q;
            end
          end
          default: begin
            drop_q     <= 1'b0;
            acc_q      <= '0;
            fill_left  <= '0;
            avail_left <= '0;
          end
        endcase
      end
      if (cmd.fill_step) begin
        wptr      <= wptr_inc;
        fill_left <= fill_left - CNT_W'(1);
      end
      if (cmd.rd_issue) begin
        rptr <= rptr_inc;
        if (!replay) begin
          avail_left <= avail_left - BURST_W'(1);
        end
      end
      if (cmd.rewind) begin
        rptr   <= PTR_W'(rew_ptr);
        replay <= 1'b1;
      end
      if (cmd.rd_load || cmd.zero_load) begin
        burst_left <= burst_left - BURST_W'(1);
      end
    end
  end

  // output register
  assign slot_free = !out_valid || out_ready;
  assign out_load  = cmd.rd_load || cmd.zero_load || cmd.stat_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= cmd.rd_load ? rdata : '0;
      last       <= cmd.stat_load || (burst_left == BURST_W'(1));
      underrun   <= cmd.rd_load && replay;
      dropped    <= cmd.stat_load && drop_q;
      accepted   <= cmd.stat_load ? COUNT_W'(acc_q) : '0;
      fill_level <= COUNT_W'(fill);
      playing    <= !awaiting && !paused;
    end
  end

  always_comb begin
    status.clr_done       = clr_addr == PTR_MAX;
    status.slot_free      = slot_free;
    status.func           = func_q;
    status.paused         = paused;
    status.burst_zero     = burst_n == '0;
    status.avail_zero     = avail_left == '0;
    status.fill_left_zero = fill_left == '0;
    status.burst_last     = burst_left == BURST_W'(1);
    status.replay         = replay;
  end

endmodule

`default_nettype wire

// ----- sv/asfur_ctrl.sv -----
// controller state machine sequencing each operation over the datapath
`default_nettype none

module asfur_ctrl
  import asfur_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.func)
          FUNC_SILENCE: state_next = ST_FILL;
          FUNC_READ: begin
            if (status.burst_zero) begin
              state_next = ST_IDLE;
            end else if (status.paused) begin
              state_next = ST_ZERO;
            end else begin
              state_next = ST_RD_NEXT;
            end
          end
          default: state_next = ST_EMIT;
        endcase
      end
      ST_FILL: begin
        if (status.fill_left_zero) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (status.slot_free && status.burst_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_NEXT: begin
        if (!status.replay && status.avail_zero) begin
          state_next = ST_REWIND;
        end else begin
          state_next = ST_RD_ADDR;
        end
      end
      ST_REWIND:  state_next = ST_RD_ADDR;
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: begin
        if (status.slot_free) begin
          if (status.burst_last) begin
            state_next = ST_IDLE;
          end else if (status.replay || !status.avail_zero) begin
            state_next = ST_RD_ADDR;
          end else begin
            state_next = ST_REWIND;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DECODE:  cmd.exec      = 1'b1;
      ST_FILL:    cmd.fill_step = !status.fill_left_zero;
      ST_EMIT:    cmd.stat_load = status.slot_free;
      ST_ZERO:    cmd.zero_load = status.slot_free;
      ST_REWIND:  cmd.rewind    = 1'b1;
      ST_RD_ADDR: cmd.rd_issue  = 1'b1;
      ST_RD_DATA: cmd.rd_load   = status.slot_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/audio_sample_fifo_underrun_replay.sv -----
// top level of the audio sample fifo with underrun replay
// Ring buffer of signed 16-bit audio samples with push, silence fill, read burst,
// skip and pause operations; a short read burst rewinds and replays stored samples.
// After reset the block sweeps zeros through every entry of the store before it
// takes the first transfer; configuration writes are taken throughout. A push, skip,
// pause or unused code passes through decode and then loads its status result. A
// silence fill writes its samples one at a time through the store's single write
// port before its result. A read burst of up to 64 samples (the MAX_BURST default)
// takes each sample through a registered store read, then an output load, with a
// rewind step when it runs short; a paused read loads one zero sample at a time.
// The output register lets a result wait while the block returns to idle.
`default_nettype none

module audio_sample_fifo_underrun_replay
  import asfur_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic        [ADDR_W-1:0]   paddr,
  input  wire logic        [DATA_W-1:0]   pwdata,
  output logic             [DATA_W-1:0]   prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [FUNC_W-1:0]   func,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic        [COUNT_W-1:0]  count,
  input  wire logic                       pause_flag,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [SAMPLE_W-1:0] sample_out,
  output logic                            last,
  output logic                            underrun,
  output logic                            dropped,
  output logic             [COUNT_W-1:0]  accepted,
  output logic             [COUNT_W-1:0]  fill_level,
  output logic                            playing
);

  logic [CH_W-1:0]  channel_count;
  logic [BLK_W-1:0] block_frames;
  cmd_t             cmd;
  status_t          status;

  asfur_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .channel_count (channel_count),
    .block_frames  (block_frames)
  );

  asfur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  asfur_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .sample_in     (sample_in),
    .count         (count),
    .pause_flag    (pause_flag),
    .channel_count (channel_count),
    .block_frames  (block_frames),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .sample_out    (sample_out),
    .last          (last),
    .underrun      (underrun),
    .dropped       (dropped),
    .accepted      (accepted),
    .fill_level    (fill_level),
    .playing       (playing)
  );

endmodule

`default_nettype wire
